### rtl/core/rnrc_pkg.sv
`timescale 1ns / 1ps
// rnrc_pkg: shared widths, request codes and the cell control struct
// for the retransmission cache; no dependencies

package rnrc_pkg;

    localparam int SEQ_BITS        = 16;
    localparam int MASK_BITS       = 16;
    localparam int HANDLE_IN_BITS  = 16;
    localparam int HANDLE_OUT_BITS = 16;

    localparam int DEF_CACHE_DEPTH = 256;
    localparam int DEF_HANDLE_BITS = 16;

    // cells per first-level reduction group
    localparam int GROUP_SIZE = 16;

    // probe index runs over the packet id and one slot per mask bit
    localparam int PROBE_BITS    = $clog2(MASK_BITS + 1);
    localparam int MASK_IDX_BITS = $clog2(MASK_BITS);

    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_NACK  = 1'b1;

    typedef struct packed {
        logic shift;
        logic advance;
        logic check;
    } cell_ctl_t;

endpackage

### rtl/core/rnrc_if.sv
`timescale 1ns / 1ps
// rnrc_req_if / rnrc_rsp_if: valid/ready channels for request and result items
// depends on rnrc_pkg for field widths

interface rnrc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [rnrc_pkg::SEQ_BITS-1:0]       seq_number;
    logic [rnrc_pkg::MASK_BITS-1:0]      lost_mask;
    logic [rnrc_pkg::HANDLE_IN_BITS-1:0] buffer_handle;

    modport source (
        output valid, req_type, seq_number, lost_mask, buffer_handle,
        input  ready
    );
    modport sink (
        input  valid, req_type, seq_number, lost_mask, buffer_handle,
        output ready
    );
endinterface

interface rnrc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [rnrc_pkg::SEQ_BITS-1:0]        resend_seq;
    logic [rnrc_pkg::HANDLE_OUT_BITS-1:0] resend_handle;
    logic                           last;

    modport source (
        output valid, resend_seq, resend_handle, last,
        input  ready
    );
    modport sink (
        input  valid, resend_seq, resend_handle, last,
        output ready
    );
endinterface

### rtl/core/rtp_nack_retransmit_cache_unit.sv
`timescale 1ns / 1ps
// rtp_nack_retransmit_cache_unit: one item at a time; a store issues one probe and a nack
// 17, one per cycle while no hit is stalled, into a 3-stage match pipeline, then the flush
// state; a nack takes longer while the result side holds ready low
// a result waits for the next hit of its item or the flush
// reset clears all cell valid bits at once, so the cache starts empty with no sweep
// depends on rnrc_pkg, rnrc_if, rnrc_cell and rnrc_ctrl

module rtp_nack_retransmit_cache_unit #(
    parameter int CACHE_DEPTH = rnrc_pkg::DEF_CACHE_DEPTH,
    parameter int HANDLE_BITS = rnrc_pkg::DEF_HANDLE_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    rnrc_req_if.sink   req,
    rnrc_rsp_if.source rsp
);
    import rnrc_pkg::*;

    localparam int NUM_GROUPS = (CACHE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_DEPTH  = NUM_GROUPS * GROUP_SIZE;

    cell_ctl_t              ctl;
    logic [SEQ_BITS-1:0]    probe_key;
    logic [SEQ_BITS-1:0]    store_seq;
    logic [HANDLE_BITS-1:0] store_handle;

    logic                   cell_valid [CACHE_DEPTH];
    logic [SEQ_BITS-1:0]    cell_seq [CACHE_DEPTH];
    logic [HANDLE_BITS-1:0] cell_handle [CACHE_DEPTH];

    logic                   hit_vec [PAD_DEPTH];
    logic [HANDLE_BITS-1:0] hit_handle_vec [PAD_DEPTH];

    logic                   grp_hit_vec [NUM_GROUPS];
    logic [HANDLE_BITS-1:0] grp_handle_vec [NUM_GROUPS];

    logic                   f_hit;
    logic [HANDLE_BITS-1:0] f_handle;

    // cell 0 takes the newest entry, the last cell drops the oldest
    for (genvar i = 0; i < CACHE_DEPTH; i++)
    begin : g_cell
        logic                   prev_valid;
        logic [SEQ_BITS-1:0]    prev_seq;
        logic [HANDLE_BITS-1:0] prev_handle;

        if (i == 0)
        begin : g_head
            assign prev_valid  = 1'b1;
            assign prev_seq    = store_seq;
            assign prev_handle = store_handle;
        end
        else
        begin : g_body
            assign prev_valid  = cell_valid[i-1];
            assign prev_seq    = cell_seq[i-1];
            assign prev_handle = cell_handle[i-1];
        end

        rnrc_cell #(
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .key         (probe_key),
            .prev_valid  (prev_valid),
            .prev_seq    (prev_seq),
            .prev_handle (prev_handle),
            .valid       (cell_valid[i]),
            .seq         (cell_seq[i]),
            .handle      (cell_handle[i]),
            .hit         (hit_vec[i]),
            .hit_handle  (hit_handle_vec[i])
        );
    end

    for (genvar p = CACHE_DEPTH; p < PAD_DEPTH; p++)
    begin : g_pad
        assign hit_vec[p]        = 1'b0;
        assign hit_handle_vec[p] = '0;
    end

    // at most one cell hits, so an or of the gated handles picks it out
    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_group
        logic                   hit_or;
        logic [HANDLE_BITS-1:0] handle_or;
        logic                   grp_hit_reg;
        logic [HANDLE_BITS-1:0] grp_handle_reg;

        always_comb
        begin
            hit_or    = 1'b0;
            handle_or = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                hit_or    = hit_or | hit_vec[g*GROUP_SIZE + j];
                handle_or = handle_or | hit_handle_vec[g*GROUP_SIZE + j];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                grp_hit_reg    <= 1'b0;
                grp_handle_reg <= '0;
            end
            else if (ctl.advance)
            begin
                grp_hit_reg    <= hit_or;
                grp_handle_reg <= handle_or;
            end
        end

        assign grp_hit_vec[g]    = grp_hit_reg;
        assign grp_handle_vec[g] = grp_handle_reg;
    end

    always_comb
    begin
        f_hit    = 1'b0;
        f_handle = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            f_hit    = f_hit | grp_hit_vec[g];
            f_handle = f_handle | grp_handle_vec[g];
        end
    end

    rnrc_ctrl #(
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .f_hit        (f_hit),
        .f_handle     (f_handle),
        .ctl          (ctl),
        .probe_key    (probe_key),
        .store_seq    (store_seq),
        .store_handle (store_handle)
    );

endmodule

### rtl/core/rnrc_cell.sv
`timescale 1ns / 1ps
// rnrc_cell: one cache entry of the insertion-order chain, with its own
// key comparator and registered hit; depends on rnrc_pkg

module rnrc_cell #(
    parameter int HANDLE_BITS = rnrc_pkg::DEF_HANDLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rnrc_pkg::cell_ctl_t           ctl,
    input  logic [rnrc_pkg::SEQ_BITS-1:0] key,
    input  logic                          prev_valid,
    input  logic [rnrc_pkg::SEQ_BITS-1:0] prev_seq,
    input  logic [HANDLE_BITS-1:0]        prev_handle,
    output logic                          valid,
    output logic [rnrc_pkg::SEQ_BITS-1:0] seq,
    output logic [HANDLE_BITS-1:0]        handle,
    output logic                          hit,
    output logic [HANDLE_BITS-1:0]        hit_handle
);
    import rnrc_pkg::*;

    logic                   valid_reg;
    logic [SEQ_BITS-1:0]    seq_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic                   hit_reg;
    logic [HANDLE_BITS-1:0] hit_handle_reg;
    logic                   match;

    assign match = valid_reg && (seq_reg == key) && ctl.check;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.shift)
            begin
                valid_reg <= prev_valid;
            end
            if (ctl.advance)
            begin
                hit_reg <= match;
            end
        end
    end

    // entries move one cell down the chain on every insert
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            seq_reg    <= prev_seq;
            handle_reg <= prev_handle;
        end
        if (ctl.advance)
        begin
            hit_handle_reg <= match ? handle_reg : '0;
        end
    end

    assign valid      = valid_reg;
    assign seq        = seq_reg;
    assign handle     = handle_reg;
    assign hit        = hit_reg;
    assign hit_handle = hit_handle_reg;

endmodule

### rtl/core/rnrc_ctrl.sv
`timescale 1ns / 1ps
// rnrc_ctrl: item sequencer, probe pipeline tags, pending result and output register
// depends on rnrc_pkg and the rnrc_req_if / rnrc_rsp_if interfaces

module rnrc_ctrl #(
    parameter int HANDLE_BITS = rnrc_pkg::DEF_HANDLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rnrc_req_if.sink                      req,
    rnrc_rsp_if.source                    rsp,
    input  logic                          f_hit,
    input  logic [HANDLE_BITS-1:0]        f_handle,
    output rnrc_pkg::cell_ctl_t           ctl,
    output logic [rnrc_pkg::SEQ_BITS-1:0] probe_key,
    output logic [rnrc_pkg::SEQ_BITS-1:0] store_seq,
    output logic [HANDLE_BITS-1:0]        store_handle
);
    import rnrc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FLUSH
    } state_t;

    state_t                     state_reg, state_next;
    logic                       kind_reg, kind_next;
    logic [SEQ_BITS-1:0]        seq_reg, seq_next;
    logic [MASK_BITS-1:0]       mask_reg, mask_next;
    logic [HANDLE_BITS-1:0]     handle_reg, handle_next;
    logic [PROBE_BITS-1:0]      idx_reg, idx_next;

    logic                       s0_occ_reg, s0_occ_next;
    logic                       s0_chk_reg, s0_chk_next;
    logic                       s0_end_reg, s0_end_next;
    logic [SEQ_BITS-1:0]        s0_key_reg, s0_key_next;
    logic                       s1_occ_reg, s1_occ_next;
    logic                       s1_end_reg, s1_end_next;
    logic [SEQ_BITS-1:0]        s1_key_reg, s1_key_next;
    logic                       s2_occ_reg, s2_occ_next;
    logic                       s2_end_reg, s2_end_next;
    logic [SEQ_BITS-1:0]        s2_key_reg, s2_key_next;

    logic                       pend_valid_reg, pend_valid_next;
    logic [SEQ_BITS-1:0]        pend_seq_reg, pend_seq_next;
    logic [HANDLE_OUT_BITS-1:0] pend_handle_reg, pend_handle_next;

    logic                       out_valid_reg, out_valid_next;
    logic [SEQ_BITS-1:0]        out_seq_reg, out_seq_next;
    logic [HANDLE_OUT_BITS-1:0] out_handle_reg, out_handle_next;
    logic                       out_last_reg, out_last_next;

    logic [HANDLE_BITS-1:0]     handle_in;
    logic [HANDLE_OUT_BITS-1:0] f_handle_out;
    logic [MASK_IDX_BITS-1:0]   mask_idx;
    logic                       probe_chk;
    logic                       probe_end;
    logic                       out_free;
    logic                       found;
    logic                       stall;
    logic                       advance;

    if (HANDLE_BITS <= HANDLE_IN_BITS)
    begin : g_in_narrow
        assign handle_in = req.buffer_handle[HANDLE_BITS-1:0];
    end
    else
    begin : g_in_wide
        assign handle_in = {{(HANDLE_BITS-HANDLE_IN_BITS){1'b0}}, req.buffer_handle};
    end

    if (HANDLE_BITS >= HANDLE_OUT_BITS)
    begin : g_out_narrow
        assign f_handle_out = f_handle[HANDLE_OUT_BITS-1:0];
    end
    else
    begin : g_out_wide
        assign f_handle_out = {{(HANDLE_OUT_BITS-HANDLE_BITS){1'b0}}, f_handle};
    end

    // probe 0 is the packet id, probe k is id+k when mask bit k-1 is set
    assign mask_idx  = MASK_IDX_BITS'(idx_reg - PROBE_BITS'(1));
    assign probe_chk = (idx_reg == '0) || mask_reg[mask_idx];
    assign probe_end = (kind_reg == REQ_STORE) || (idx_reg == PROBE_BITS'(MASK_BITS));

    assign out_free = !out_valid_reg || rsp.ready;
    assign found    = s2_occ_reg && f_hit;
    // a second hit can only move on when the held one has somewhere to go
    assign stall    = found && (kind_reg == REQ_NACK) && pend_valid_reg && !out_free;
    assign advance  = !stall;

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        seq_next         = seq_reg;
        mask_next        = mask_reg;
        handle_next      = handle_reg;
        idx_next         = idx_reg;
        s0_occ_next      = s0_occ_reg;
        s0_chk_next      = s0_chk_reg;
        s0_end_next      = s0_end_reg;
        s0_key_next      = s0_key_reg;
        s1_occ_next      = s1_occ_reg;
        s1_end_next      = s1_end_reg;
        s1_key_next      = s1_key_reg;
        s2_occ_next      = s2_occ_reg;
        s2_end_next      = s2_end_reg;
        s2_key_next      = s2_key_reg;
        pend_valid_next  = pend_valid_reg;
        pend_seq_next    = pend_seq_reg;
        pend_handle_next = pend_handle_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_seq_next     = out_seq_reg;
        out_handle_next  = out_handle_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next   = req.req_type;
                    seq_next    = req.seq_number;
                    mask_next   = req.lost_mask;
                    handle_next = handle_in;
                    idx_next    = '0;
                    state_next  = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (advance)
                begin
                    if (probe_end)
                    begin
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + PROBE_BITS'(1);
                    end
                end
            end
            ST_WAIT:
            begin
                if (advance && s2_occ_reg && s2_end_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_seq_next    = pend_seq_reg;
                    out_handle_next = pend_handle_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance)
        begin
            s0_occ_next = (state_reg == ST_ISSUE);
            s0_chk_next = (state_reg == ST_ISSUE) && probe_chk;
            s0_end_next = probe_end;
            s0_key_next = seq_reg + SEQ_BITS'(idx_reg);
            s1_occ_next = s0_occ_reg;
            s1_end_next = s0_end_reg;
            s1_key_next = s0_key_reg;
            s2_occ_next = s1_occ_reg;
            s2_end_next = s1_end_reg;
            s2_key_next = s1_key_reg;

            // hold the newest hit back until we know whether it is the last one
            if (found && (kind_reg == REQ_NACK))
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_seq_next    = pend_seq_reg;
                    out_handle_next = pend_handle_reg;
                    out_last_next   = 1'b0;
                end
                pend_valid_next  = 1'b1;
                pend_seq_next    = s2_key_reg;
                pend_handle_next = f_handle_out;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            kind_reg        <= REQ_STORE;
            seq_reg         <= '0;
            mask_reg        <= '0;
            handle_reg      <= '0;
            idx_reg         <= '0;
            s0_occ_reg      <= 1'b0;
            s0_chk_reg      <= 1'b0;
            s0_end_reg      <= 1'b0;
            s0_key_reg      <= '0;
            s1_occ_reg      <= 1'b0;
            s1_end_reg      <= 1'b0;
            s1_key_reg      <= '0;
            s2_occ_reg      <= 1'b0;
            s2_end_reg      <= 1'b0;
            s2_key_reg      <= '0;
            pend_valid_reg  <= 1'b0;
            pend_seq_reg    <= '0;
            pend_handle_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_seq_reg     <= '0;
            out_handle_reg  <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            seq_reg         <= seq_next;
            mask_reg        <= mask_next;
            handle_reg      <= handle_next;
            idx_reg         <= idx_next;
            s0_occ_reg      <= s0_occ_next;
            s0_chk_reg      <= s0_chk_next;
            s0_end_reg      <= s0_end_next;
            s0_key_reg      <= s0_key_next;
            s1_occ_reg      <= s1_occ_next;
            s1_end_reg      <= s1_end_next;
            s1_key_reg      <= s1_key_next;
            s2_occ_reg      <= s2_occ_next;
            s2_end_reg      <= s2_end_next;
            s2_key_reg      <= s2_key_next;
            pend_valid_reg  <= pend_valid_next;
            pend_seq_reg    <= pend_seq_next;
            pend_handle_reg <= pend_handle_next;
            out_valid_reg   <= out_valid_next;
            out_seq_reg     <= out_seq_next;
            out_handle_reg  <= out_handle_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign req.ready = (state_reg == ST_IDLE);

    assign rsp.valid         = out_valid_reg;
    assign rsp.resend_seq    = out_seq_reg;
    assign rsp.resend_handle = out_handle_reg;
    assign rsp.last          = out_last_reg;

    // a store that missed enters the chain when its probe leaves the pipeline
    assign ctl.shift   = advance && s2_occ_reg && !f_hit && (kind_reg == REQ_STORE);
    assign ctl.advance = advance;
    assign ctl.check   = s0_chk_reg;

    assign probe_key    = s0_key_reg;
    assign store_seq    = s2_key_reg;
    assign store_handle = handle_reg;

endmodule

### rtl/core/rnrc_checker.sv
`timescale 1ns / 1ps
// rnrc_checker: port-level assertions for the retransmission cache, bound to the top
// depends on rnrc_pkg and rtp_nack_retransmit_cache_unit

module rnrc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 req_valid,
    input logic                                 req_ready,
    input logic                                 req_type,
    input logic                                 rsp_valid,
    input logic                                 rsp_ready,
    input logic [rnrc_pkg::SEQ_BITS-1:0]        rsp_seq,
    input logic [rnrc_pkg::HANDLE_OUT_BITS-1:0] rsp_handle,
    input logic                                 rsp_last
);
    import rnrc_pkg::*;

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted on two back-to-back cycles");

    // a result without last means the nack is still being worked on
    a_busy_mid_nack: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !req_ready)
        else $error("ready for a new item before the last result");

    a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == REQ_STORE) |=> !$rose(rsp_valid))
        else $error("store item produced a result");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seq)
            && $stable(rsp_handle) && $stable(rsp_last))
        else $error("result item dropped or changed while stalled");

endmodule

bind rtp_nack_retransmit_cache_unit rnrc_checker u_rnrc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_type   (req.req_type),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_seq    (rsp.resend_seq),
    .rsp_handle (rsp.resend_handle),
    .rsp_last   (rsp.last)
);
